// ===== design/sobel_pkg.sv =====
// Shared types and constants for the Sobel edge threshold unit.
// Depends on nothing; imported by sobel_edge_threshold_unit.
package sobel_pkg;

   // Line memory depth and derived widths.
   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int CNT_W     = ADDR_W + 1;

   // Field widths.
   localparam int PIX_W      = 8;
   localparam int THR_W      = 11;
   localparam int WID_W      = 11;
   localparam int HGT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Output codes and minimum frame size.
   localparam logic [PIX_W-1:0] PIX_MAX  = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;
   localparam int               MIN_DIM  = 3;

   // Register reset values.
   localparam logic [THR_W-1:0] THR_RESET = 11'd30;
   localparam logic [WID_W-1:0] WID_RESET = 11'd640;
   localparam logic [HGT_W-1:0] HGT_RESET = 16'd480;

   // Item kinds on the request channel.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WIDTH     = 2'd1,
      CSR_HEIGHT    = 2'd2
   } csr_index_type;

endpackage

// ===== design/sobel_edge_threshold_unit.sv =====
// Sobel 3x3 edge detector with threshold, streaming one pixel per beat.
// A result is registered and leaves in the cycle after the beat that completes it; in raster terms
// results trail the input by one line plus one pixel, and flush beats drain the rest.
// Throughput: one beat per cycle while the result register can advance; req_ready drops in the cycle
// after each register write while the line memory prefetch is redone. Reset clears counters, the window
// and the configuration registers; the two line memories are not cleared and need no clearing pass.
module sobel_edge_threshold_unit
   import sobel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [PIX_W-1:0]      req_gray_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_end_of_line,
   output logic                  rsp_end_of_frame,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Prefetch address: flush beats read from the pending count, pixels from the column.
   function automatic logic [ADDR_W-1:0] fetch_addr(input logic [CNT_W-1:0]  pend,
                                                    input logic [ADDR_W-1:0] col,
                                                    input logic [CNT_W-1:0]  weff);
      logic [CNT_W-1:0] pmax;
      logic [CNT_W-1:0] last;
      logic [CNT_W-1:0] diff;
      pmax = weff + CNT_W'(1);
      last = weff - CNT_W'(1);
      diff = weff - pend;
      if (pend == '0) begin
         return col;
      end else if (pend >= pmax) begin
         return last[ADDR_W-1:0];
      end else begin
         return diff[ADDR_W-1:0];
      end
   endfunction

   // Configuration and control state.
   logic [THR_W-1:0]  threshold_ff;
   logic [WID_W-1:0]  width_ff;
   logic [HGT_W-1:0]  height_ff;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [HGT_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  pending_ff, pending_in;
   logic              fetch_ok_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic              rsp_eol_ff, rsp_eol_in;
   logic              rsp_eof_ff, rsp_eof_in;

   // Line memories, prefetched read data and the 3x3 window.
   logic [PIX_W-1:0]  line_above_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  line_two_mem   [MAX_WIDTH];
   logic [PIX_W-1:0]  rd_above_ff;
   logic [PIX_W-1:0]  rd_two_ff;
   logic [PIX_W-1:0]  win_ff [9];

   // Derived values.
   logic [CNT_W-1:0]  w_eff, wm1, pend_max, pclamp, fcol;
   logic [ADDR_W-1:0] wm1_a, c, fetch_col, faddr;
   logic [HGT_W-1:0]  h_eff, hm1, r;
   logic              csr_acc, req_acc, acc_pixel, acc_flush, advance;
   logic              from_two, last_col;
   logic [PIX_W+1:0]  gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
   logic [PIX_W+2:0]  mag;
   logic              edge_hit;

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = fetch_ok_ff && advance;
   assign req_acc   = req_valid && req_ready;
   assign acc_pixel = req_acc && (req_kind == KIND_PIXEL);
   assign acc_flush = req_acc && (req_kind == KIND_FLUSH);

   // Effective frame size and clamped counters.
   always_comb begin
      if (int'(width_ff) < MIN_DIM) begin
         w_eff = CNT_W'(MIN_DIM);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(width_ff);
      end
      wm1      = w_eff - CNT_W'(1);
      wm1_a    = wm1[ADDR_W-1:0];
      pend_max = w_eff + CNT_W'(1);
      h_eff    = (int'(height_ff) < MIN_DIM) ? HGT_W'(MIN_DIM) : height_ff;
      hm1      = h_eff - HGT_W'(1);
      c        = ({1'b0, col_ff} > wm1) ? wm1_a : col_ff;
      r        = (row_ff > hm1) ? hm1 : row_ff;
      pclamp   = (pending_ff > pend_max) ? pend_max : pending_ff;
      from_two = (pclamp == pend_max);
      fcol     = from_two ? wm1 : (w_eff - pclamp);
      last_col = (c == wm1_a);
   end

   // Gradient magnitude over the window as it stands after this pixel shifts in.
   always_comb begin
      gx_pos = {2'b00, win_ff[7]} + {1'b0, win_ff[8], 1'b0} + {2'b00, req_gray_pixel};
      gx_neg = {2'b00, win_ff[1]} + {1'b0, win_ff[2], 1'b0} + {2'b00, rd_two_ff};
      gy_pos = {2'b00, rd_two_ff} + {1'b0, rd_above_ff, 1'b0} + {2'b00, req_gray_pixel};
      gy_neg = {2'b00, win_ff[1]} + {1'b0, win_ff[4], 1'b0} + {2'b00, win_ff[7]};
      gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
      gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
      mag    = {1'b0, gx_abs} + {1'b0, gy_abs};
      edge_hit = (mag >= threshold_ff);
   end

   // Next counter state and the result for this beat.
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      pending_in   = pending_ff;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_eol_in   = rsp_eol_ff;
      rsp_eof_in   = rsp_eof_ff;
      fetch_col    = c;
      if (acc_flush && (pending_ff != '0)) begin
         pending_in   = pclamp - CNT_W'(1);
         rsp_valid_in = 1'b1;
         rsp_pixel_in = from_two ? rd_two_ff : rd_above_ff;
         rsp_eol_in   = (fcol == wm1);
         rsp_eof_in   = (pclamp == CNT_W'(1));
      end else if (acc_pixel) begin
         pending_in = '0;
         if (last_col) begin
            col_in = '0;
            if (r == hm1) begin
               row_in     = '0;
               pending_in = pend_max;
            end else begin
               row_in = r + HGT_W'(1);
            end
         end else begin
            col_in = c + ADDR_W'(1);
            row_in = r;
         end
         fetch_col = col_in;
         // Border and right-edge results both come from the old centre-right tap.
         rsp_pixel_in = win_ff[5];
         rsp_eof_in   = 1'b0;
         rsp_eol_in   = (c == '0);
         if (c == '0) begin
            rsp_valid_in = (r >= HGT_W'(2));
         end else begin
            rsp_valid_in = (r >= HGT_W'(1));
            if ((r >= HGT_W'(2)) && (c >= ADDR_W'(2))) begin
               rsp_pixel_in = edge_hit ? PIX_MAX : PIX_ZERO;
            end
         end
      end
      faddr = fetch_addr(pending_in, fetch_col, w_eff);
   end

   // Line memories: write at the current column, prefetch for the next beat.
   always_ff @(posedge clock) begin
      if (acc_pixel) begin
         line_above_mem[c] <= req_gray_pixel;
         line_two_mem[c]   <= rd_above_ff;
      end
      if (acc_pixel && (faddr == c)) begin
         rd_above_ff <= req_gray_pixel;
         rd_two_ff   <= rd_above_ff;
      end else begin
         rd_above_ff <= line_above_mem[faddr];
         rd_two_ff   <= line_two_mem[faddr];
      end
   end

   // Window shift on each pixel beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (acc_pixel) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]     <= win_ff[k*3 + 1];
            win_ff[k*3 + 1] <= win_ff[k*3 + 2];
         end
         win_ff[2] <= rd_two_ff;
         win_ff[5] <= rd_above_ff;
         win_ff[8] <= req_gray_pixel;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
         width_ff     <= WID_RESET;
         height_ff    <= HGT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         pending_ff   <= '0;
         fetch_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         pending_ff   <= pending_in;
         fetch_ok_ff  <= !csr_acc;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_acc) begin
            unique case (csr_index)
               CSR_THRESHOLD: threshold_ff <= csr_data[THR_W-1:0];
               CSR_WIDTH:     width_ff     <= csr_data[WID_W-1:0];
               CSR_HEIGHT:    height_ff    <= csr_data[HGT_W-1:0];
               default:       ;
            endcase
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_eol_ff   <= rsp_eol_in;
      rsp_eof_ff   <= rsp_eof_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_end_of_line  = rsp_eol_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   // A register write must force the prefetch to be redone before the next beat.
   a_csr_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_acc |=> !req_ready)
      else $error("request accepted right after a register write");

   // Outputs are pending only at the start of a line.
   a_pend_col0: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == '0) || (col_ff == '0))
      else $error("pending outputs with a nonzero column");

   // The last flush beat of a frame empties the pending count.
   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      (acc_flush && (pclamp == CNT_W'(1))) |=> (pending_ff == '0) && rsp_end_of_frame)
      else $error("frame drain did not end cleanly");

   // The pending count never exceeds one line plus one pixel.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(MAX_WIDTH + 1))
      else $error("pending count out of range");

endmodule
